@@ hw/rtl/gda_pkg.sv @@
// Shared types, constants and calendar helpers for the Gregorian date unit.
package gda_pkg;

  localparam int YEAR_W = 15;  // working year, covers estimate plus one
  localparam int SER_W  = 23;  // serial day number
  localparam int DOY_W  = 9;   // day of year

  localparam logic [1:0] KIND_ADD = 2'd0;

  localparam logic [1:0] YSEL_FIRST  = 2'd0;
  localparam logic [1:0] YSEL_SECOND = 2'd1;
  localparam logic [1:0] YSEL_CUR    = 2'd2;
  localparam logic [1:0] YSEL_NEXT   = 2'd3;

  localparam logic [13:0] YEAR_LAST = 14'd9999;
  localparam logic [21:0] DIST_SAT  = 22'h3F_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [15:0] day_count;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
  } req_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [21:0] days_between;
    logic        first_earlier;
    logic        dates_equal;
    logic        range_error;
  } rsp_t;

  typedef struct packed {
    logic       load_req;
    logic [1:0] ysel;
    logic       cap_a;
    logic       cap_b;
    logic       shift;
    logic       est;
    logic       y_dec;
    logic       y_inc;
    logic       cap_doy;
    logic       m_dec;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic kind_dist;
    logic shift_err;
    logic y_pos;
    logic dby_gt_s;
    logic month_step;
  } sts_t;

  // Month 0 counts as January, 13 to 15 as December.
  function automatic logic [3:0] month_clamp(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (m == 4'd0) r = 4'd1;
    if (m > 4'd12) r = 4'd12;
    return r;
  endfunction

  // Days in the months before m (1..12), with the leap day after February.
  function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] m,
                                                         input logic leap);
    logic [DOY_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (m > 4'd2 && leap) d = d + 9'd1;
    return d;
  endfunction

endpackage

@@ hw/rtl/gda_stream_if.sv @@
// Valid/ready channel carrying one word of a given payload type.
interface gda_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/gda_year_unit.sv @@
// Two-stage unit giving days before a year and its leap flag.
module gda_year_unit
  import gda_pkg::*;
(
  input  logic              clk,
  input  logic [YEAR_W-1:0] year_in,
  output logic [SER_W-1:0]  dby,
  output logic              leap
);

  logic [YEAR_W-1:0] yb_r;
  logic [SER_W-1:0]  y365_r;
  logic [13:0]       q4_r;
  logic [8:0]        q100_r;
  logic [6:0]        q400_r;
  logic [8:0]        qy_r;
  logic [SER_W-1:0]  dby_r;
  logic              leap_r;

  logic [15:0] y_p3;
  logic [14:0] y_p99;
  logic [14:0] y_p399;
  logic [23:0] m365;
  logic [27:0] m100;
  logic [27:0] m400;
  logic [27:0] my;
  logic [14:0] qy100;

  // x/100 and x/400 by reciprocal 5243/2^19 and 5243/2^21, exact below 43690
  assign y_p3   = {1'b0, year_in} + 16'd3;
  assign y_p99  = year_in + 15'd99;
  assign y_p399 = year_in + 15'd399;
  assign m365   = {9'd0, year_in} * 24'd365;
  assign m100   = {13'd0, y_p99} * 28'd5243;
  assign m400   = {13'd0, y_p399} * 28'd5243;
  assign my     = {13'd0, year_in} * 28'd5243;

  always_ff @(posedge clk) begin
    yb_r   <= year_in;
    y365_r <= m365[SER_W-1:0];
    q4_r   <= y_p3[15:2];
    q100_r <= m100[27:19];
    q400_r <= m400[27:21];
    qy_r   <= my[27:19];
  end

  assign qy100 = {6'd0, qy_r} * 15'd100;

  always_ff @(posedge clk) begin
    dby_r  <= y365_r + {9'd0, q4_r} - {14'd0, q100_r} + {16'd0, q400_r};
    leap_r <= (yb_r[1:0] == 2'b00) && ((qy100 != yb_r) || (qy_r[1:0] == 2'b00));
  end

  assign dby  = dby_r;
  assign leap = leap_r;

endmodule

@@ hw/rtl/gda_datapath.sv @@
// Datapath: request hold, serial numbers, year and month walk, result word.
module gda_datapath
  import gda_pkg::*;
(
  input  logic clk,
  input  req_t req_in,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  req_t              req_r;
  logic              earlier_r;
  logic              equal_r;
  logic [SER_W-1:0]  ser_a_r;
  logic [SER_W-1:0]  ser_b_r;
  logic [SER_W-1:0]  s_r;
  logic              err_r;
  logic [YEAR_W-1:0] y_r;
  logic [DOY_W-1:0]  doy_r;
  logic              leapf_r;
  logic [3:0]        m_r;
  rsp_t              rsp_r;

  logic [YEAR_W-1:0] y_sel;
  logic [SER_W-1:0]  dby;
  logic              leap;
  logic [SER_W-1:0]  ser_first;
  logic [SER_W-1:0]  ser_second;
  logic [SER_W:0]    s_wide;
  logic              shift_err;
  logic [34:0]       y_est;
  logic [DOY_W-1:0]  dbm_cur;
  logic [SER_W-1:0]  diff;
  logic [DOY_W-1:0]  day_wide;
  rsp_t              rsp_nxt;

  always_comb begin
    case (cmd.ysel)
      YSEL_FIRST:  y_sel = {1'b0, req_r.first_year};
      YSEL_SECOND: y_sel = {1'b0, req_r.second_year};
      YSEL_CUR:    y_sel = y_r;
      default:     y_sel = y_r + 15'd1;
    endcase
  end

  gda_year_unit u_year (
    .clk     (clk),
    .year_in (y_sel),
    .dby     (dby),
    .leap    (leap)
  );

  // Serial numbers are kept one above the day count from 1 January of year 0
  assign ser_first  = dby + {14'd0, days_before_month(month_clamp(req_r.first_month), leap)}
                    + {18'd0, req_r.first_day};
  assign ser_second = dby + {14'd0, days_before_month(month_clamp(req_r.second_month), leap)}
                    + {18'd0, req_r.second_day};

  always_comb begin
    if (req_r.kind == KIND_ADD) begin
      shift_err = (ser_a_r == '0) && (req_r.day_count == '0);
      s_wide    = {1'b0, ser_a_r} + {8'd0, req_r.day_count} - 24'd1;
    end else begin
      shift_err = ser_a_r <= {7'd0, req_r.day_count};
      s_wide    = {1'b0, ser_a_r} - {8'd0, req_r.day_count} - 24'd1;
    end
  end

  // Year estimate: s * 400 / 146097 approximated by s * 2870 / 2^20
  assign y_est   = {12'd0, s_r} * 35'd2870;
  assign dbm_cur = days_before_month(m_r, leapf_r);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r     <= req_in;
      earlier_r <= {req_in.first_year, req_in.first_month, req_in.first_day}
                 < {req_in.second_year, req_in.second_month, req_in.second_day};
      equal_r   <= {req_in.first_year, req_in.first_month, req_in.first_day}
                == {req_in.second_year, req_in.second_month, req_in.second_day};
    end
    if (cmd.cap_a) ser_a_r <= ser_first;
    if (cmd.cap_b) ser_b_r <= ser_second;
    if (cmd.shift) begin
      err_r <= shift_err;
      s_r   <= s_wide[SER_W-1:0];
    end
    if (cmd.est) y_r <= y_est[34:20];
    else if (cmd.y_dec) y_r <= y_r - 15'd1;
    else if (cmd.y_inc) y_r <= y_r + 15'd1;
    if (cmd.cap_doy) begin
      doy_r   <= DOY_W'(s_r - dby);
      leapf_r <= leap;
    end
    if (cmd.cap_doy) m_r <= 4'd12;
    else if (cmd.m_dec) m_r <= m_r - 4'd1;
    if (cmd.load_out) rsp_r <= rsp_nxt;
  end

  assign diff     = (ser_a_r >= ser_b_r) ? ser_a_r - ser_b_r : ser_b_r - ser_a_r;
  assign day_wide = doy_r - dbm_cur + 9'd1;

  always_comb begin
    rsp_nxt               = '0;
    rsp_nxt.first_earlier = earlier_r;
    rsp_nxt.dates_equal   = equal_r;
    if (req_r.kind[1]) begin
      rsp_nxt.days_between = diff[SER_W-1] ? DIST_SAT : diff[21:0];
    end else if (err_r || (y_r == '0) || (y_r > {1'b0, YEAR_LAST})) begin
      rsp_nxt.range_error = 1'b1;
    end else begin
      rsp_nxt.result_day   = day_wide[4:0];
      rsp_nxt.result_month = m_r;
      rsp_nxt.result_year  = y_r[13:0];
    end
  end

  assign sts.kind_dist  = req_r.kind[1];
  assign sts.shift_err  = shift_err;
  assign sts.y_pos      = (y_r != '0);
  assign sts.dby_gt_s   = (dby > s_r);
  assign sts.month_step = (m_r > 4'd1) && (dbm_cur > doy_r);

  assign rsp = rsp_r;

endmodule

@@ hw/rtl/gda_ctrl.sv @@
// Controller: sequences serial build, year correction and month search.
module gda_ctrl
  import gda_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_Y1    = 4'd1;
  localparam logic [3:0] S_Y2    = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_EST   = 4'd4;
  localparam logic [3:0] S_DOWN  = 4'd5;
  localparam logic [3:0] S_UP    = 4'd6;
  localparam logic [3:0] S_YFIN  = 4'd7;
  localparam logic [3:0] S_MONTH = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [1:0] WAIT_LAST = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_year;
  logic       eval;

  assign eval = (cnt_r == WAIT_LAST);

  always_comb begin
    unique case (state_r) inside
      S_Y1, S_Y2, S_DOWN, S_UP, S_YFIN: in_year = 1'b1;
      default:                          in_year = 1'b0;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.ysel  = YSEL_FIRST;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_Y1;
        end
      end
      S_Y1: begin
        cmd.ysel = YSEL_FIRST;
        if (eval) begin
          cmd.cap_a = 1'b1;
          state_nxt = sts.kind_dist ? S_Y2 : S_SHIFT;
        end
      end
      S_Y2: begin
        cmd.ysel = YSEL_SECOND;
        if (eval) begin
          cmd.cap_b = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = sts.shift_err ? S_DONE : S_EST;
      end
      S_EST: begin
        cmd.est   = 1'b1;
        state_nxt = S_DOWN;
      end
      S_DOWN: begin
        cmd.ysel = YSEL_CUR;
        if (eval) begin
          if (sts.y_pos && sts.dby_gt_s) cmd.y_dec = 1'b1;
          else state_nxt = S_UP;
        end
      end
      S_UP: begin
        cmd.ysel = YSEL_NEXT;
        if (eval) begin
          if (!sts.dby_gt_s) cmd.y_inc = 1'b1;
          else state_nxt = S_YFIN;
        end
      end
      S_YFIN: begin
        cmd.ysel = YSEL_CUR;
        if (eval) begin
          cmd.cap_doy = 1'b1;
          state_nxt   = S_MONTH;
        end
      end
      S_MONTH: begin
        if (sts.month_step) cmd.m_dec = 1'b1;
        else state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Restart the year unit wait whenever the year operand changes
  assign cnt_nxt = (in_year && !eval) ? cnt_r + 2'd1 : 2'd0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold ready low while reset is asserted so no word looks taken.
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result word overwritten while held");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_Y1 && cnt_r == 2'd0))
    else $error("accepted word did not start the first year lookup");

  a_dec_positive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.y_dec |-> sts.y_pos)
    else $error("year decremented below zero");

  a_dec_rewait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DOWN && cmd.y_dec) |=> (state_r == S_DOWN && cnt_r == 2'd0))
    else $error("year walk did not restart the lookup wait");
`endif

endmodule

@@ hw/rtl/gregorian_date_arithmetic_core.sv @@
// Sequence: days-between looks up both years and captures both serial numbers; a day shift looks up
//   the first year, shifts, estimates the year, walks it down then up (at least 2 year lookups) and
//   steps the month down (0 to 11 steps); a shift that falls below day zero skips to the result.
// Throughput: one word in flight; the next word is taken in the idle cycle after the result is
//   loaded, and the result load waits while a previous result word is still held.
// Reset: rst_n synchronous active low clears the controller state and the output valid flag and
//   holds input ready low; there are no stores to clear, and a word can be taken the cycle after.
module gregorian_date_arithmetic_core
  import gda_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  gda_stream_if.sink   in_req,
  gda_stream_if.source out_rsp
);

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  logic in_ready;
  logic out_valid;

  // Controller: walks each word through serial build and, for a day shift, year fix-up and month search.
  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds the request, the serial day numbers, the working year
  // and month, and the output word register.
  gda_datapath u_dp (
    .clk    (clk),
    .req_in (in_req.payload),
    .cmd    (cmd),
    .sts    (sts),
    .rsp    (rsp)
  );

  // Input side is free whenever the controller is idle and out of reset, even while the
  // previous result word still waits in the output register.
  assign in_req.ready    = in_ready;
  assign out_rsp.valid   = out_valid;
  assign out_rsp.payload = rsp;

endmodule
